// ===== rtl/tile_grid_rect_collision_top_defines.svh =====
// ============================================================================
// Tile grid rectangle collision: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef TILE_GRID_RECT_COLLISION_TOP_DEFINES_SVH
`define TILE_GRID_RECT_COLLISION_TOP_DEFINES_SVH

// Same-cycle implication.
`define TGRC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TGRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tgrc_pkg.sv =====
// ============================================================================
// Tile grid rectangle collision: package
// Shared constants, register indexes and the types passed between modules.
// ============================================================================
package tgrc_pkg;

    localparam int DEFAULT_GRID_COLUMNS = 64;
    localparam int DEFAULT_GRID_ROWS    = 64;

    // Divider operand widths: a pixel sum plus a tile size minus one fits 17 bits.
    localparam int DIV_NUM_W = 17;
    localparam int DIV_DEN_W = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address = 4 * index).
    localparam logic [1:0] REG_TILE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_TILE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_COLUMNS_IN_USE = 2'd2;
    localparam logic [1:0] REG_ROWS_IN_USE    = 2'd3;

    localparam logic [7:0] TILE_WIDTH_RST     = 8'd16;
    localparam logic [7:0] TILE_HEIGHT_RST    = 8'd16;
    localparam logic [6:0] COLUMNS_IN_USE_RST = 7'd64;
    localparam logic [6:0] ROWS_IN_USE_RST    = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [5:0]  cell_row;
        logic [5:0]  cell_column;
        logic        cell_solid;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [14:0] rect_width;
        logic [14:0] rect_height;
    } item_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

// ===== rtl/tgrc_item_if.sv =====
// ============================================================================
// Tile grid rectangle collision: input channel
// Valid/ready channel carrying one write or query item per beat.
// ============================================================================
interface tgrc_item_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [5:0]         cell_row;
    logic [5:0]         cell_column;
    logic               cell_solid;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;

    modport source (
        output valid, operation, cell_row, cell_column, cell_solid,
               rect_x, rect_y, rect_width, rect_height,
        input  ready
    );

    modport sink (
        input  valid, operation, cell_row, cell_column, cell_solid,
               rect_x, rect_y, rect_width, rect_height,
        output ready
    );
endinterface

// ===== rtl/tgrc_result_if.sv =====
// ============================================================================
// Tile grid rectangle collision: result channel
// Valid/ready channel carrying one hit flag per beat.
// ============================================================================
interface tgrc_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

// ===== rtl/tile_grid_rect_collision_top.sv =====
// ============================================================================
// Tile grid rectangle collision: top level
// Query: the result beat follows the four span divisions, run one after another on one divider,
// then the span check and the scan of the cells, up to the first solid cell. A cell write
// sets its result beat in ST_WRITE. One item is in flight at a time; the next beat is taken
// only after the result beat has been taken. After reset the grid RAM is cleared, all
// GRID_ROWS*GRID_COLUMNS entries, with the input held off.
// ============================================================================
`include "tile_grid_rect_collision_top_defines.svh"

module tile_grid_rect_collision_top #(
    parameter int GRID_COLUMNS = tgrc_pkg::DEFAULT_GRID_COLUMNS,
    parameter int GRID_ROWS    = tgrc_pkg::DEFAULT_GRID_ROWS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tgrc_item_if.sink                       item,
    tgrc_result_if.source                   result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tgrc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tgrc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tgrc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    // The grid is one bit per cell in a RAM of GRID_ROWS*GRID_COLUMNS entries, addressed
    // row * GRID_COLUMNS + column. A query first runs the four span divisions one after
    // another on a single shared divider (left, top, right, bottom), then walks the span
    // row by row: ST_SCAN_RD presents the cell address, ST_SCAN_CHK looks at the read data.
    localparam int DEPTH = GRID_ROWS * GRID_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(GRID_COLUMNS + 1);
    localparam int RW    = $clog2(GRID_ROWS + 1);
    localparam int NW    = tgrc_pkg::DIV_NUM_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SPAN,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RESP
    } state_t;

    state_t          state_reg;
    tgrc_pkg::item_t item_reg;
    logic [1:0]      phase_reg;
    logic [AW-1:0]   clr_addr_reg;
    logic            result_valid_reg;
    logic            hit_reg;

    logic [7:0] tile_width_reg;
    logic [7:0] tile_height_reg;
    logic [6:0] columns_in_use_reg;
    logic [6:0] rows_in_use_reg;

    // Span registers hold indexes already clamped to the counts in use.
    logic [CW-1:0] left_reg;
    logic [CW-1:0] right_reg;
    logic [RW-1:0] top_reg;
    logic [RW-1:0] bottom_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    // ------------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is tied
    // high, so there are no wait states.
    // ------------------------------------------------------------------------
    logic cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_width_reg     <= tgrc_pkg::TILE_WIDTH_RST;
            tile_height_reg    <= tgrc_pkg::TILE_HEIGHT_RST;
            columns_in_use_reg <= tgrc_pkg::COLUMNS_IN_USE_RST;
            rows_in_use_reg    <= tgrc_pkg::ROWS_IN_USE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                tgrc_pkg::REG_TILE_WIDTH:     tile_width_reg     <= pwdata[7:0];
                tgrc_pkg::REG_TILE_HEIGHT:    tile_height_reg    <= pwdata[7:0];
                tgrc_pkg::REG_COLUMNS_IN_USE: columns_in_use_reg <= pwdata[6:0];
                tgrc_pkg::REG_ROWS_IN_USE:    rows_in_use_reg    <= pwdata[6:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tgrc_pkg::REG_TILE_WIDTH:     prdata = 32'(tile_width_reg);
            tgrc_pkg::REG_TILE_HEIGHT:    prdata = 32'(tile_height_reg);
            tgrc_pkg::REG_COLUMNS_IN_USE: prdata = 32'(columns_in_use_reg);
            tgrc_pkg::REG_ROWS_IN_USE:    prdata = 32'(rows_in_use_reg);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Effective configuration: a zero tile size acts as one, and counts above
    // the grid size saturate to it.
    // ------------------------------------------------------------------------
    logic [7:0]    tw_eff;
    logic [7:0]    th_eff;
    logic [CW-1:0] cols_lim;
    logic [RW-1:0] rows_lim;

    always_comb
    begin
        tw_eff   = (tile_width_reg == 8'd0) ? 8'd1 : tile_width_reg;
        th_eff   = (tile_height_reg == 8'd0) ? 8'd1 : tile_height_reg;
        cols_lim = (32'(columns_in_use_reg) > 32'(GRID_COLUMNS)) ?
                   CW'(GRID_COLUMNS) : CW'(columns_in_use_reg);
        rows_lim = (32'(rows_in_use_reg) > 32'(GRID_ROWS)) ?
                   RW'(GRID_ROWS) : RW'(rows_in_use_reg);
    end

    // ------------------------------------------------------------------------
    // Divider operands. Phase bit 0 picks the axis (x or y), bit 1 picks start
    // or end edge. A start edge divides the left/top position, taken as zero
    // when negative. An end edge divides pos + size + tile - 1 for a ceiling;
    // a non-positive pos + size gives a numerator of zero.
    // ------------------------------------------------------------------------
    tgrc_pkg::div_ctl_t div_ctl;
    tgrc_pkg::div_sts_t div_sts;
    logic [NW-1:0]      div_num;
    logic [7:0]         div_den;
    logic [NW-1:0]      div_quo;

    logic [15:0] pos_sel;
    logic [14:0] size_sel;
    logic [NW-1:0] edge_sum;

    always_comb
    begin
        pos_sel  = phase_reg[0] ? item_reg.rect_y : item_reg.rect_x;
        size_sel = phase_reg[0] ? item_reg.rect_height : item_reg.rect_width;
        div_den  = phase_reg[0] ? th_eff : tw_eff;
        edge_sum = {pos_sel[15], pos_sel} + NW'(size_sel);
        if (!phase_reg[1])
        begin
            div_num = pos_sel[15] ? '0 : NW'(pos_sel[14:0]);
        end
        else if (edge_sum[NW-1] || (edge_sum == '0))
        begin
            div_num = '0;
        end
        else
        begin
            div_num = edge_sum + NW'(div_den) - NW'(1);
        end
    end

    assign div_ctl.start = (state_reg == ST_DIV_START);

    tgrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_num),
        .divisor  (div_den),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    // Quotients clamped to the limits in use; clamping a start edge cannot
    // change whether the span is empty.
    logic [CW-1:0] quo_col;
    logic [RW-1:0] quo_row;

    always_comb
    begin
        quo_col = (div_quo > NW'(cols_lim)) ? cols_lim : CW'(div_quo);
        quo_row = (div_quo > NW'(rows_lim)) ? rows_lim : RW'(div_quo);
    end

    // ------------------------------------------------------------------------
    // Grid RAM. Written by the clearing sweep and by cell writes; read by the
    // scan. Writes outside the grid are dropped.
    // ------------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;
    logic          cell_in_grid;

    always_comb
    begin
        cell_in_grid = (32'(item_reg.cell_row) < 32'(GRID_ROWS)) &&
                       (32'(item_reg.cell_column) < 32'(GRID_COLUMNS));
        ram_raddr    = AW'(32'(row_reg) * 32'(GRID_COLUMNS) + 32'(col_reg));
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = 1'b0;
        end
        else
        begin
            ram_we    = (state_reg == ST_WRITE) && cell_in_grid;
            ram_waddr = AW'(32'(item_reg.cell_row) * 32'(GRID_COLUMNS) +
                            32'(item_reg.cell_column));
            ram_wdata = item_reg.cell_solid;
        end
    end

    tgrc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Sequencer. Input is taken only in ST_IDLE; the result beat waits in an
    // output register until the sink takes it.
    // ------------------------------------------------------------------------
    logic item_beat;

    assign item_beat    = item.valid && item.ready;
    assign item.ready   = (state_reg == ST_IDLE);
    assign result.valid = result_valid_reg;
    assign result.hit   = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            phase_reg        <= '0;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
            hit_reg          <= 1'b0;
            left_reg         <= '0;
            right_reg        <= '0;
            top_reg          <= '0;
            bottom_reg       <= '0;
            col_reg          <= '0;
            row_reg          <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (item.valid)
                    begin
                        phase_reg <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= (item.operation == tgrc_pkg::OP_WRITE) ?
                                     ST_WRITE : ST_DIV_START;
                    end
                end
                ST_WRITE:
                begin
                    result_valid_reg <= 1'b1;
                    state_reg        <= ST_RESP;
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_sts.done)
                    begin
                        case (phase_reg)
                            2'd0:    left_reg   <= quo_col;
                            2'd1:    top_reg    <= quo_row;
                            2'd2:    right_reg  <= quo_col;
                            default: bottom_reg <= quo_row;
                        endcase
                        phase_reg <= phase_reg + 1'b1;
                        state_reg <= (phase_reg == 2'd3) ? ST_SPAN : ST_DIV_START;
                    end
                end
                ST_SPAN:
                begin
                    col_reg <= left_reg;
                    row_reg <= top_reg;
                    if ((left_reg >= right_reg) || (top_reg >= bottom_reg))
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_RESP;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN_RD;
                    end
                end
                ST_SCAN_RD:
                begin
                    state_reg <= ST_SCAN_CHK;
                end
                ST_SCAN_CHK:
                begin
                    if (ram_rdata)
                    begin
                        hit_reg          <= 1'b1;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_RESP;
                    end
                    else if (CW'(col_reg + 1'b1) != right_reg)
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= ST_SCAN_RD;
                    end
                    else if (RW'(row_reg + 1'b1) != bottom_reg)
                    begin
                        col_reg   <= left_reg;
                        row_reg   <= row_reg + 1'b1;
                        state_reg <= ST_SCAN_RD;
                    end
                    else
                    begin
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_RESP;
                    end
                end
                ST_RESP:
                begin
                    if (result.ready)
                    begin
                        result_valid_reg <= 1'b0;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Item payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (item_beat)
        begin
            item_reg.operation   <= item.operation;
            item_reg.cell_row    <= item.cell_row;
            item_reg.cell_column <= item.cell_column;
            item_reg.cell_solid  <= item.cell_solid;
            item_reg.rect_x      <= item.rect_x;
            item_reg.rect_y      <= item.rect_y;
            item_reg.rect_width  <= item.rect_width;
            item_reg.rect_height <= item.rect_height;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    logic write_state;
    logic scan_in_span;

    assign write_state  = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
    assign scan_in_span = (col_reg >= left_reg) && (col_reg < right_reg) &&
                          (row_reg >= top_reg) && (row_reg < bottom_reg);

    `TGRC_ASSERT_IMPLY(a_no_take_while_result, result.valid, !item.ready, "taken while full")
    `TGRC_ASSERT_NEXT(a_one_item_in_flight, item_beat, !item.ready, "second item taken")
    `TGRC_ASSERT_IMPLY(a_ram_write_source, ram_we, write_state, "stray grid write")
    `TGRC_ASSERT_IMPLY(a_scan_in_span, state_reg == ST_SCAN_RD, scan_in_span, "scan off span")
    `TGRC_ASSERT_IMPLY(a_div_in_wait, div_sts.busy, state_reg == ST_DIV_WAIT, "stray divide")

endmodule

// ===== rtl/tgrc_ram.sv =====
// ============================================================================
// Tile grid rectangle collision: generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module tgrc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tgrc_div.sv =====
// ============================================================================
// Tile grid rectangle collision: iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ============================================================================
module tgrc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tgrc_pkg::div_ctl_t             ctl,
    input  logic [tgrc_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [tgrc_pkg::DIV_DEN_W-1:0] divisor,
    output tgrc_pkg::div_sts_t             sts,
    output logic [tgrc_pkg::DIV_NUM_W-1:0] quotient
);

    localparam int NW = tgrc_pkg::DIV_NUM_W;
    localparam int DW = tgrc_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [DW-1:0]    rem_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_sub;
    logic          fits;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_next;

    // Shift in the next dividend bit; subtract the divisor when it fits.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NW-1]};
        rem_sub   = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
        rem_next  = fits ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
        quo_next  = {quo_reg[NW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            cnt_reg  <= CNT_W'(NW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            den_reg <= divisor;
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule
